/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property check failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* sv/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, lexer mode codes, character codes and byte classifiers.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] mode_t;

  // token kinds
  localparam kind_t KIND_IDENT  = 3'd0;
  localparam kind_t KIND_LBRACE = 3'd1;
  localparam kind_t KIND_RBRACE = 3'd2;
  localparam kind_t KIND_LPAREN = 3'd3;
  localparam kind_t KIND_RPAREN = 3'd4;
  localparam kind_t KIND_SEMI   = 3'd5;
  localparam kind_t KIND_END    = 3'd6;

  // lexer modes
  localparam mode_t MODE_NORMAL  = 3'd0;
  localparam mode_t MODE_IDENT   = 3'd1;
  localparam mode_t MODE_SLASH   = 3'd2;
  localparam mode_t MODE_COMMENT = 3'd3;
  localparam mode_t MODE_STRING  = 3'd4;

  // character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // letter or underscore: may open an identifier
  function automatic logic is_alpha_us(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == CH_UNDER);
  endfunction

  // may continue an identifier
  function automatic logic is_ident_char(input logic [7:0] b);
    return is_alpha_us(b) || ((b >= 8'h30) && (b <= 8'h39));
  endfunction

  // punctuation kind, KIND_IDENT when the byte is no punctuation
  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    unique case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

/* sv/source_text_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming C-style lexer: one byte in, identifier, punctuation, end tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one source byte per word plus a
//   final-byte flag. Output channel (out_valid/out_ready) carries one token per
//   word; out_last_of_run marks the last token caused by one input byte.
//   Each byte yields zero to three tokens; a final byte always adds an end
//   token (kind 6), after which all lexer state returns to its reset values.
//   Output: tokens of a byte are registered in the result queue when the byte
//   is accepted. Throughput: one byte per cycle while each byte yields at most
//   one token and the receiver keeps up; a byte with more tokens holds up the
//   input until the receiver has taken enough of them. The four-word result
//   queue sets this: a byte is taken while at most one token is still queued.
//   Receiver stall: tokens wait in the queue; once two or more are waiting,
//   in_ready drops until at most one is left.
//   Reset (rst_n low, synchronous): queue emptied, line/column/offset zero,
//   mode back to normal.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_text_tokenizer_unit #(
  parameter int LINE_BITS   = 16,
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_final_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_token_kind,
  output logic [LINE_BITS-1:0]   out_token_line,
  output logic [LINE_BITS-1:0]   out_column_start,
  output logic [LINE_BITS-1:0]   out_column_end,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [OFFSET_BITS-1:0] out_token_length,
  output logic                   out_last_of_run
);

  import stt_pkg::*;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef struct packed {
    kind_t kind;
    line_t line;
    line_t cs;
    line_t ce;
    off_t  off;
    off_t  len;
    logic  last;
  } res_t;

  // lexer state
  mode_t mode_r;
  logic  sq_r, esc_r, cr_r;
  line_t line_r, col_r, ist_col_r;
  off_t  off_r, ist_off_r;

  // result queue
  res_t       fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;

  logic in_fire, out_fire;

  assign in_ready = (cnt_r <= 3'd1);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && out_ready;

  // saturating increments
  line_t col_inc, line_inc;
  off_t  off_inc;
  assign col_inc  = (col_r == '1) ? col_r : col_r + line_t'(1);
  assign line_inc = (line_r == '1) ? line_r : line_r + line_t'(1);
  assign off_inc  = (off_r == '1) ? off_r : off_r + off_t'(1);

  // updated state for this byte (before end-of-document clearing)
  mode_t mode_upd;
  logic  sq_upd, esc_upd, cr_upd, normal;
  line_t line_upd, col_upd, ist_col_upd;
  off_t  off_upd, ist_off_upd;
  logic  ident_done;
  kind_t pk;
  logic [7:0] b;

  assign b  = in_text_byte;
  assign pk = punct_kind(b);

  always_comb begin
    mode_upd    = mode_r;
    sq_upd      = sq_r;
    esc_upd     = esc_r;
    cr_upd      = 1'b0;
    line_upd    = line_r;
    col_upd     = col_r;
    ist_col_upd = ist_col_r;
    ist_off_upd = ist_off_r;
    normal      = 1'b0;
    ident_done  = 1'b0;

    // mode step
    unique case (mode_r)
      MODE_IDENT: begin
        if (is_ident_char(b)) begin
          col_upd = col_inc;
        end else begin
          ident_done = 1'b1;
          mode_upd   = MODE_NORMAL;
          normal     = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_upd = MODE_COMMENT;
          col_upd  = col_inc;
        end else begin
          mode_upd = MODE_NORMAL;
          normal   = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if ((b == CH_CR) || (b == CH_LF)) begin
          mode_upd = MODE_NORMAL;
          normal   = 1'b1;
        end else begin
          col_upd = col_inc;
        end
      end
      MODE_STRING: begin
        if (esc_r) begin
          esc_upd = 1'b0;
          col_upd = col_inc;
        end else if (b == CH_BSLASH) begin
          esc_upd = 1'b1;
          col_upd = col_inc;
        end else if ((b == CH_CR) || (b == CH_LF)) begin
          mode_upd = MODE_NORMAL;
          normal   = 1'b1;
        end else begin
          if (b == (sq_r ? CH_SQUOTE : CH_DQUOTE)) mode_upd = MODE_NORMAL;
          col_upd = col_inc;
        end
      end
      default: begin
        mode_upd = MODE_NORMAL;
        normal   = 1'b1;
      end
    endcase

    // normal lexing of the byte
    if (normal) begin
      if (cr_r && (b == CH_LF)) begin
        // LF closing a CR-LF pair: nothing to count
      end else if ((b == CH_CR) || (b == CH_LF)) begin
        line_upd = line_inc;
        col_upd  = '0;
        cr_upd   = (b == CH_CR);
      end else if (b == CH_SLASH) begin
        mode_upd = MODE_SLASH;
        col_upd  = col_inc;
      end else if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
        mode_upd = MODE_STRING;
        sq_upd   = (b == CH_SQUOTE);
        esc_upd  = 1'b0;
        col_upd  = col_inc;
      end else if (is_alpha_us(b)) begin
        mode_upd    = MODE_IDENT;
        ist_off_upd = off_r;
        ist_col_upd = col_r;
        col_upd     = col_inc;
      end else begin
        col_upd = col_inc;
      end
    end

    off_upd = off_inc;
  end

  // candidate results: ended identifier, punctuation, final identifier, end
  res_t       res [4];
  logic [3:0] en;
  logic [1:0] pos [4];
  logic [2:0] n_res;
  off_t       len0, len2;

  assign len0 = (off_r >= ist_off_r) ? off_r - ist_off_r : '0;
  assign len2 = (off_upd >= ist_off_upd) ? off_upd - ist_off_upd : '0;

  assign en[0] = ident_done;
  assign en[1] = normal && !(cr_r && (b == CH_LF)) && (b != CH_CR) && (b != CH_LF) &&
                 (b != CH_SLASH) && (b != CH_DQUOTE) && (b != CH_SQUOTE) &&
                 !is_alpha_us(b) && (pk != KIND_IDENT);
  assign en[2] = in_final_byte && (mode_upd == MODE_IDENT);
  assign en[3] = in_final_byte;

  assign pos[0] = 2'd0;
  assign pos[1] = {1'b0, en[0]};
  assign pos[2] = pos[1] + {1'b0, en[1]};
  assign pos[3] = pos[2] + {1'b0, en[2]};
  assign n_res  = {1'b0, pos[3]} + {2'b0, en[3]};

  always_comb begin
    res[0] = '{kind: KIND_IDENT, line: line_r, cs: ist_col_r, ce: col_r,
               off: ist_off_r, len: len0, last: 1'b0};
    res[1] = '{kind: pk, line: line_r, cs: col_r, ce: col_inc,
               off: off_r, len: off_t'(1), last: 1'b0};
    res[2] = '{kind: KIND_IDENT, line: line_upd, cs: ist_col_upd, ce: col_upd,
               off: ist_off_upd, len: len2, last: 1'b0};
    res[3] = '{kind: KIND_END, line: line_upd, cs: col_upd, ce: col_upd,
               off: off_upd, len: '0, last: 1'b0};
    for (int k = 0; k < 4; k++) begin
      res[k].last = ({1'b0, pos[k]} == (n_res - 3'd1));
    end
  end

  // lexer state registers; a final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_final_byte)) begin
      mode_r    <= MODE_NORMAL;
      sq_r      <= 1'b0;
      esc_r     <= 1'b0;
      cr_r      <= 1'b0;
      line_r    <= '0;
      col_r     <= '0;
      off_r     <= '0;
      ist_off_r <= '0;
      ist_col_r <= '0;
    end else if (in_fire) begin
      mode_r    <= mode_upd;
      sq_r      <= sq_upd;
      esc_r     <= esc_upd;
      cr_r      <= cr_upd;
      line_r    <= line_upd;
      col_r     <= col_upd;
      off_r     <= off_upd;
      ist_off_r <= ist_off_upd;
      ist_col_r <= ist_col_upd;
    end
  end

  // queue payload: packed write of the enabled results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 4; k++) begin
        if (en[k]) fifo_r[wr_ptr_r + pos[k]] <= res[k];
      end
    end
  end

  // queue pointers and fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire)  cnt_nxt = cnt_nxt + n_res;
    if (out_fire) cnt_nxt = cnt_nxt - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire)  wr_ptr_r <= wr_ptr_r + n_res[1:0];
      if (out_fire) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  // output word at the queue head
  res_t head;
  assign head             = fifo_r[rd_ptr_r];
  assign out_token_kind   = head.kind;
  assign out_token_line   = head.line;
  assign out_column_start = head.cs;
  assign out_column_end   = head.ce;
  assign out_start_offset = head.off;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last;

  // checks
  `ASSERT_NEVER(a_cnt_ovf, clk, rst_n, cnt_r > 3'd4)
  `ASSERT_PROP(a_ptr_cnt, clk, rst_n, cnt_r[1:0] == (wr_ptr_r - rd_ptr_r))
  `ASSERT_PROP(a_fin_clear, clk, rst_n, (in_fire && in_final_byte) |=> ((off_r == '0) && (mode_r == MODE_NORMAL) && (line_r == '0)))
  `ASSERT_PROP(a_fin_word, clk, rst_n, (in_fire && in_final_byte) |=> out_valid)

endmodule

/* verif/source_text_tokenizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// Watches both channels of the tokenizer, predicts its tokens, compares them.
// Every accepted byte is run through a private lexer copy that queues the
// tokens it should produce; every accepted token is matched against the
// oldest queued one. Failures and the number of tokens still owed are handed
// to the testbench top.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_token_kind,
  input  logic [15:0] out_token_line,
  input  logic [15:0] out_column_start,
  input  logic [15:0] out_column_end,
  input  logic [23:0] out_start_offset,
  input  logic [23:0] out_token_length,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] col_start;
    logic [15:0] col_end;
    logic [23:0] offset;
    logic [23:0] length;
    logic        last;
  } token_t;

  token_t expected_tokens[$];

  // private lexer state
  mode_t       lx_mode;
  logic        single_quote;
  logic        escape_next;
  logic        after_cr;
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] id_col;
  logic [23:0] cur_offset;
  logic [23:0] id_offset;
  int          errs;

  // saturating counters
  function automatic logic [15:0] bump_line(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [23:0] bump_offset(input logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 24'd1;
  endfunction

  // byte classes
  function automatic logic opens_word(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == CH_UNDER);
  endfunction

  function automatic logic continues_word(input logic [7:0] b);
    return opens_word(b) || (b >= "0" && b <= "9");
  endfunction

  function automatic kind_t punct_of(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic void clear_lexer();
    lx_mode      = MODE_NORMAL;
    single_quote = 1'b0;
    escape_next  = 1'b0;
    after_cr     = 1'b0;
    cur_line     = '0;
    cur_col      = '0;
    cur_offset   = '0;
    id_offset    = '0;
    id_col       = '0;
  endfunction

  function automatic void push_token(input kind_t k, input logic [15:0] ln,
                                     input logic [15:0] cs, input logic [15:0] ce,
                                     input logic [23:0] off, input logic [23:0] len);
    token_t t;
    t.kind      = k;
    t.line      = ln;
    t.col_start = cs;
    t.col_end   = ce;
    t.offset    = off;
    t.length    = len;
    t.last      = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void push_ident();
    push_token(KIND_IDENT, cur_line, id_col, cur_col, id_offset,
               (cur_offset >= id_offset) ? cur_offset - id_offset : 24'd0);
  endfunction

  // one byte through the lexer; queues the tokens it yields
  function automatic void lex_byte(input logic [7:0] b, input logic fin);
    int          n_prior;
    logic        was_cr;
    logic        lex_normal;
    kind_t       k;
    logic [15:0] next_col;
    token_t      t;

    n_prior    = expected_tokens.size();
    was_cr     = after_cr;
    after_cr   = 1'b0;
    lex_normal = 1'b0;

    case (lx_mode)
      MODE_IDENT: begin
        if (continues_word(b)) begin
          cur_col = bump_line(cur_col);
        end else begin
          push_ident();
          lx_mode    = MODE_NORMAL;
          lex_normal = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          lx_mode = MODE_COMMENT;
          cur_col = bump_line(cur_col);
        end else begin
          lx_mode    = MODE_NORMAL;
          lex_normal = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_CR || b == CH_LF) begin
          lx_mode    = MODE_NORMAL;
          lex_normal = 1'b1;
        end else begin
          cur_col = bump_line(cur_col);
        end
      end
      MODE_STRING: begin
        if (escape_next) begin
          escape_next = 1'b0;
          cur_col     = bump_line(cur_col);
        end else if (b == CH_BSLASH) begin
          escape_next = 1'b1;
          cur_col     = bump_line(cur_col);
        end else if (b == CH_CR || b == CH_LF) begin
          // unescaped line break leaves the string unclosed
          lx_mode    = MODE_NORMAL;
          lex_normal = 1'b1;
        end else begin
          if (b == (single_quote ? CH_SQUOTE : CH_DQUOTE))
            lx_mode = MODE_NORMAL;
          cur_col = bump_line(cur_col);
        end
      end
      default: begin
        lx_mode    = MODE_NORMAL;
        lex_normal = 1'b1;
      end
    endcase

    if (lex_normal) begin
      if (was_cr && b == CH_LF) begin
        // LF completing a CR-LF pair: offset only
      end else if (b == CH_CR || b == CH_LF) begin
        cur_line = bump_line(cur_line);
        cur_col  = '0;
        after_cr = (b == CH_CR);
      end else if (b == CH_SLASH) begin
        lx_mode = MODE_SLASH;
        cur_col = bump_line(cur_col);
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        lx_mode      = MODE_STRING;
        single_quote = (b == CH_SQUOTE);
        escape_next  = 1'b0;
        cur_col      = bump_line(cur_col);
      end else if (opens_word(b)) begin
        lx_mode   = MODE_IDENT;
        id_offset = cur_offset;
        id_col    = cur_col;
        cur_col   = bump_line(cur_col);
      end else begin
        k        = punct_of(b);
        next_col = bump_line(cur_col);
        if (k != KIND_IDENT)
          push_token(k, cur_line, cur_col, next_col, cur_offset, 24'd1);
        cur_col = next_col;
      end
    end

    cur_offset = bump_offset(cur_offset);

    // end of document: flush identifier, add end marker, start over
    if (fin) begin
      if (lx_mode == MODE_IDENT)
        push_ident();
      push_token(KIND_END, cur_line, cur_col, cur_col, cur_offset, 24'd0);
      clear_lexer();
    end

    if (expected_tokens.size() > n_prior) begin
      t      = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endfunction

  // compare first, then predict: a token never answers the byte of its own edge
  always @(posedge clk) begin : watch
    token_t got;
    token_t want;
    if (!rst_n) begin
      clear_lexer();
      expected_tokens.delete();
      errs = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind      = out_token_kind;
        got.line      = out_token_line;
        got.col_start = out_column_start;
        got.col_end   = out_column_end;
        got.offset    = out_start_offset;
        got.length    = out_token_length;
        got.last      = out_last_of_run;
        if (expected_tokens.size() == 0) begin
          if (errs < 10)
            $display("%0t: token with none expected: kind %0d line %0d col %0d..%0d",
                     $realtime, got.kind, got.line, got.col_start, got.col_end);
          errs++;
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            if (errs < 10) begin
              $display("%0t: token mismatch", $realtime);
              $display("  expected kind %0d line %0d col %0d..%0d off %0d len %0d last %0b",
                       want.kind, want.line, want.col_start, want.col_end,
                       want.offset, want.length, want.last);
              $display("  actual   kind %0d line %0d col %0d..%0d off %0d len %0d last %0b",
                       got.kind, got.line, got.col_start, got.col_end,
                       got.offset, got.length, got.last);
            end
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        lex_byte(in_text_byte, in_final_byte);
    end
    pending    <= expected_tokens.size();
    fail_count <= errs;
  end

endmodule

/* verif/source_text_tokenizer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_test
// Stimulus and verdict for the streaming C-style tokenizer.
// A directed stretch walks every token kind, comments, strings with escapes,
// line break forms and document ends; random documents built from
// well-formed pieces mixed with noise bytes follow under changing idle and
// stall rates.
// Token checking is done by source_text_tokenizer_checker.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_test;
  import stt_pkg::*;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_text_byte  = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  out_token_kind;
  logic [15:0] out_token_line;
  logic [15:0] out_column_start;
  logic [15:0] out_column_end;
  logic [23:0] out_start_offset;
  logic [23:0] out_token_length;
  logic        out_last_of_run;
  int          fail_count;
  int          pending;

  int          sender_idle    = 0;
  int          receiver_stall = 0;
  int          byte_count     = 0;
  logic [7:0]  doc_bytes[$];

  source_text_tokenizer_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_column_start (out_column_start),
    .out_column_end   (out_column_end),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  source_text_tokenizer_checker token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_column_start (out_column_start),
    .out_column_end   (out_column_end),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall);
  end

  // run limit
  initial begin
    #200_000;
    $display("source_text_tokenizer_unit test failed");
    $finish;
  end

  task automatic set_idling(input int idle_pct, input int stall_pct);
    sender_idle = idle_pct;
    receiver_stall <= stall_pct;
  endtask

  // one word on the input channel, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    byte_count++;
  endtask

  // hold off the sender until every expected token is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // append one byte to the document under construction
  function automatic void add_byte(input logic [7:0] v);
    doc_bytes.insert(doc_bytes.size(), v);
  endfunction

  function automatic logic [7:0] word_byte(input logic allow_digit);
    logic [7:0] b;
    case ($urandom_range(allow_digit ? 3 : 2))
      0:       b = "a" + 8'($urandom_range(25));
      1:       b = "A" + 8'($urandom_range(25));
      2:       b = CH_UNDER;
      default: b = "0" + 8'($urandom_range(9));
    endcase
    return b;
  endfunction

  // a document of mostly well-formed pieces with random content
  function automatic void build_doc();
    int         target;
    logic [7:0] q;
    doc_bytes.delete();
    target = $urandom_range(30, 3);
    while (doc_bytes.size() < target) begin
      case ($urandom_range(11))
        0, 1, 2, 3: begin
          add_byte(word_byte(1'b0));
          repeat ($urandom_range(7)) add_byte(word_byte(1'b1));
        end
        4: begin
          case ($urandom_range(4))
            0:       add_byte(CH_LBRACE);
            1:       add_byte(CH_RBRACE);
            2:       add_byte(CH_LPAREN);
            3:       add_byte(CH_RPAREN);
            default: add_byte(CH_SEMI);
          endcase
        end
        5: add_byte($urandom_range(1) ? 8'h20 : 8'h09);
        6: begin
          case ($urandom_range(2))
            0: add_byte(CH_CR);
            1: add_byte(CH_LF);
            default: begin
              add_byte(CH_CR);
              add_byte(CH_LF);
            end
          endcase
        end
        7: begin
          // line comment, body may hold any byte
          add_byte(CH_SLASH);
          add_byte(CH_SLASH);
          repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
          add_byte($urandom_range(1) ? CH_LF : CH_CR);
        end
        8: begin
          // quoted string with escapes; sometimes left open
          q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
          add_byte(q);
          repeat ($urandom_range(6)) begin
            if ($urandom_range(3) == 0) begin
              add_byte(CH_BSLASH);
              add_byte(8'($urandom_range(255)));
            end else begin
              add_byte(8'($urandom_range(126, 32)));
            end
          end
          case ($urandom_range(3))
            0, 1: add_byte(q);
            2:    add_byte($urandom_range(1) ? CH_LF : CH_CR);
            default: ;
          endcase
        end
        9:  add_byte(CH_SLASH);
        10: add_byte(8'($urandom_range(255)));
        default: add_byte("0" + 8'($urandom_range(9)));
      endcase
    end
  endfunction

  initial begin
    int   i;
    int   phase;
    logic close_doc;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every kind, comments, strings, line breaks, document ends
    set_idling(12, 12);
    send_byte(CH_UNDER, 1'b0);
    send_byte("z", 1'b0);
    send_byte("9", 1'b0);
    send_byte(CH_LBRACE, 1'b0);    // identifier ends on a token byte
    send_byte(CH_RBRACE, 1'b0);
    send_byte(CH_LPAREN, 1'b0);
    send_byte(CH_RPAREN, 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_byte(CH_SLASH, 1'b0);     // lone slash
    send_byte("x", 1'b0);
    send_byte(CH_SLASH, 1'b0);
    send_byte(CH_SLASH, 1'b0);     // comment opens
    send_byte(8'hFF, 1'b0);
    send_byte(CH_CR, 1'b0);        // CR-LF pair closes the comment
    send_byte(CH_LF, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0);    // escaped LF stays in the string
    send_byte(CH_LF, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);    // other quote does not close
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0);    // escaped CR
    send_byte(CH_CR, 1'b0);
    send_byte(CH_CR, 1'b0);        // string left open by a line break
    send_byte(8'h00, 1'b0);
    send_byte("A", 1'b0);
    send_byte(CH_SEMI, 1'b1);      // identifier, semicolon and end marker
    send_byte(8'h80, 1'b1);        // one-byte document
    drain();

    // random documents under four idling mixes
    byte_count = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(62, 0);
        2:       set_idling(0, 62);
        default: set_idling(12, 12);
      endcase
      while (byte_count < (phase + 1) * 80) begin
        build_doc();
        close_doc = ($urandom_range(9) != 0);
        for (i = 0; i < doc_bytes.size(); i++)
          send_byte(doc_bytes[i], close_doc && (i == doc_bytes.size() - 1));
      end
      if (phase == 1)
        drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("source_text_tokenizer_unit test passed");
    else
      $display("source_text_tokenizer_unit test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/stt_pkg.sv
sv/source_text_tokenizer_unit.sv
verif/source_text_tokenizer_checker.sv
verif/source_text_tokenizer_unit_test.sv
